[design/lgbt_pkg.sv]
// ----------------------------------------------------------------------------
// lgbt_pkg
// Shared types and constants of the log-grid bilinear table lookup.
// ----------------------------------------------------------------------------
package lgbt_pkg;

  typedef logic [2:0]  reg_index_t;
  typedef logic [23:0] cfg_data_t;

  // configuration register indexes
  localparam reg_index_t REG_LOG_MIN_LAMBDA  = 3'd0;
  localparam reg_index_t REG_INV_STEP_LAMBDA = 3'd1;
  localparam reg_index_t REG_COUNT_LAMBDA    = 3'd2;
  localparam reg_index_t REG_LOG_MIN_MU      = 3'd3;
  localparam reg_index_t REG_INV_STEP_MU     = 3'd4;
  localparam reg_index_t REG_COUNT_MU        = 3'd5;

  // item kinds
  localparam logic KIND_QUERY = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // fraction bits of the query arguments
  localparam int VALUE_FRAC = 16;
  // log of a zero argument
  localparam int LOG_FLOOR = -8388608;

  // position of the leading one; zero input gives zero
  function automatic logic [4:0] lead_one(input logic [31:0] x);
    logic [4:0] msb;
    msb = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) begin
        msb = 5'(i);
      end
    end
    return msb;
  endfunction

endpackage

[design/lgbt_if.sv]
// ----------------------------------------------------------------------------
// lgbt_request_if / lgbt_result_if
// Valid/ready channels of the log-grid bilinear table lookup.
// ----------------------------------------------------------------------------
interface lgbt_request_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] lambda_value;
  logic [31:0] mu_value;
  logic [5:0]  row;
  logic [5:0]  column;
  logic [31:0] entry;

  modport source (output valid, kind, lambda_value, mu_value, row, column, entry,
                  input ready);
  modport sink   (input valid, kind, lambda_value, mu_value, row, column, entry,
                  output ready);
endinterface

interface lgbt_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] interpolated;

  modport source (output valid, interpolated, input ready);
  modport sink   (input valid, interpolated, output ready);
endinterface

[design/lgbt_ram.sv]
// ----------------------------------------------------------------------------
// lgbt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lgbt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data while stalled
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/log_grid_bilinear_table_lookup_top.sv]
// ----------------------------------------------------------------------------
// log_grid_bilinear_table_lookup_top
// Bilinear lookup over a stored grid, addressed by log2 of two arguments.
//
//   channel   direction  payload
//   request   in         kind, lambda_value, mu_value, row, column, entry
//   result    out        interpolated (queries only)
//   cfg_*     in         cfg_index, cfg_data (plain write, no read-back)
//
// One item enters per cycle while the pipe is not held. The pipe depth is set
// by the log2 squaring chain, one stage per fraction bit. Writes travel the
// same pipe and reach the table at the read stage, so queries see writes in
// item order. The whole pipe holds when the output register is full and not
// taken. rst clears valid bits and configuration; the table holds no reset.
// ----------------------------------------------------------------------------
module log_grid_bilinear_table_lookup_top #(
  parameter int LAMBDA_POINTS = 64,
  parameter int MU_POINTS     = 64,
  parameter int FRAC_BITS     = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  lgbt_request_if.sink          request,
  lgbt_result_if.source         result,
  input  logic                  cfg_enable,
  input  lgbt_pkg::reg_index_t  cfg_index,
  input  lgbt_pkg::cfg_data_t   cfg_data
);

  import lgbt_pkg::*;

  localparam int F       = FRAC_BITS;
  localparam int DEPTH   = LAMBDA_POINTS * MU_POINTS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int LOG_W   = (F + 6 > 24) ? F + 6 : 24;
  localparam int D_W     = LOG_W + 1;
  localparam int PROD_W  = D_W - 1 + 24;
  localparam int POS_W   = F + 8;
  localparam int CMP_W   = (PROD_W - F > POS_W) ? PROD_W - F : POS_W;
  localparam int PR_W    = F + 34;
  localparam int SUM_W   = PR_W + 1;

  // stage indexes
  localparam int S_LOG   = F + 3;
  localparam int S_MUL   = F + 4;
  localparam int S_CLP   = F + 5;
  localparam int S_ADR   = F + 6;
  localparam int S_CEL   = F + 7;
  localparam int S_BL1   = F + 8;
  localparam int S_BL2   = F + 9;
  localparam int S_BL3   = F + 10;
  localparam int LAST    = F + 11;
  localparam int NST     = F + 12;

  localparam logic [LOG_W-1:0] LOG_FLOOR_W = LOG_W'(LOG_FLOOR);
  localparam logic [F:0]       ONE_W       = (F + 1)'(1) << F;
  localparam logic signed [SUM_W-1:0] HALF    = SUM_W'(1) << (F - 1);
  localparam logic signed [SUM_W-1:0] RES_MAX = SUM_W'(32'h7fffffff);
  localparam logic signed [SUM_W-1:0] RES_MIN = ~RES_MAX;

  typedef struct packed {
    logic                         kind;
    logic                         wok;
    logic [ADDR_W-1:0]            waddr;
    logic [31:0]                  entry;
    logic [1:0][31:0]             x;
    logic [1:0][4:0]              msb;
    logic [1:0]                   zero;
    logic [1:0][31:0]             m;
    logic [1:0][F-1:0]            frac;
    logic [1:0][D_W-1:0]          d;
    logic [1:0][PROD_W-1:0]       prod;
    logic [1:0][POS_W-1:0]        pos;
    logic [3:0][ADDR_W-1:0]       addr;
    logic [F-1:0]                 fl;
    logic [F-1:0]                 fm;
    logic [3:0][PR_W-1:0]         pr;
    logic [31:0]                  top;
    logic [31:0]                  bot;
    logic [31:0]                  res;
  } stage_t;

  // configuration
  logic [1:0][23:0] cfg_lmin;
  logic [1:0][23:0] cfg_inv;
  logic [1:0][6:0]  cfg_cnt;
  logic [1:0][POS_W-1:0] lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_lmin <= '0;
      cfg_inv  <= {24'd65536, 24'd65536};
      cfg_cnt  <= {7'd64, 7'd64};
    end else if (cfg_enable) begin
      unique case (cfg_index)
        REG_LOG_MIN_LAMBDA:  cfg_lmin[0] <= cfg_data;
        REG_INV_STEP_LAMBDA: cfg_inv[0]  <= cfg_data;
        REG_COUNT_LAMBDA:    cfg_cnt[0]  <= cfg_data[6:0];
        REG_LOG_MIN_MU:      cfg_lmin[1] <= cfg_data;
        REG_INV_STEP_MU:     cfg_inv[1]  <= cfg_data;
        REG_COUNT_MU:        cfg_cnt[1]  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // last legal position: (count-1) points, just below the last one
  always_comb begin
    logic [8:0] c9, eff, pts;
    for (int j = 0; j < 2; j++) begin
      c9  = 9'(cfg_cnt[j]);
      pts = (j == 0) ? 9'(LAMBDA_POINTS) : 9'(MU_POINTS);
      if (c9 < 9'd2) begin
        eff = 9'd2;
      end else if (c9 > pts) begin
        eff = pts;
      end else begin
        eff = c9;
      end
      lim[j] = (POS_W'(eff - 9'd1) << F) - POS_W'(1);
    end
  end

  // pipeline
  stage_t          st [NST];
  stage_t          nx [NST];
  logic [NST-1:0]  vld;
  logic            en;
  logic [3:0][31:0] cellv;

  assign en            = !(vld[LAST] && st[LAST].kind == KIND_QUERY) || result.ready;
  assign request.ready = en;

  always_comb begin
    logic [63:0]            mm;
    logic [32:0]            sq;
    logic signed [LOG_W-1:0] lg;
    logic [CMP_W-1:0]       pw;
    logic [7:0]             rl, cm;
    logic signed [PR_W-1:0] ca, wb;
    logic [F:0]             wf;
    logic signed [SUM_W-1:0] s, t;

    mm = '0; sq = '0; lg = '0; pw = '0; rl = '0; cm = '0;
    ca = '0; wb = '0; wf = '0; s = '0; t = '0;

    nx[0] = st[0];
    for (int k = 1; k < NST; k++) begin
      nx[k] = st[k-1];
    end

    // capture
    nx[0].kind  = request.kind;
    nx[0].x[0]  = request.lambda_value;
    nx[0].x[1]  = request.mu_value;
    nx[0].entry = request.entry;
    nx[0].waddr = ADDR_W'(int'(request.row) * MU_POINTS + int'(request.column));
    nx[0].wok   = (request.kind == KIND_WRITE) && (int'(request.row) < LAMBDA_POINTS)
                  && (int'(request.column) < MU_POINTS);

    for (int j = 0; j < 2; j++) begin
      // leading one
      nx[1].msb[j]  = lead_one(st[0].x[j]);
      nx[1].zero[j] = (st[0].x[j] == '0);
      // normalize to Q1.31
      nx[2].m[j]    = st[1].x[j] << (5'd31 - st[1].msb[j]);
      nx[2].frac[j] = '0;
    end

    // one fraction bit per stage by squaring
    for (int i = 0; i < F; i++) begin
      for (int j = 0; j < 2; j++) begin
        mm = {32'd0, st[2+i].m[j]} * {32'd0, st[2+i].m[j]};
        sq = mm[63:31];
        nx[3+i].frac[j] = {st[2+i].frac[j][F-2:0], sq[32]};
        nx[3+i].m[j]    = sq[32] ? sq[32:1] : sq[31:0];
      end
    end

    for (int j = 0; j < 2; j++) begin
      // log minus first grid point
      if (st[S_LOG-1].zero[j]) begin
        lg = LOG_FLOOR_W;
      end else begin
        lg = ((LOG_W'(st[S_LOG-1].msb[j]) - LOG_W'(VALUE_FRAC)) << F)
             + LOG_W'(st[S_LOG-1].frac[j]);
      end
      nx[S_LOG].d[j] = D_W'(lg) - D_W'($signed(cfg_lmin[j]));

      // scale by reciprocal step
      if ($signed(st[S_MUL-1].d[j]) > 0) begin
        nx[S_MUL].prod[j] = PROD_W'(st[S_MUL-1].d[j][D_W-2:0]) * PROD_W'(cfg_inv[j]);
      end else begin
        nx[S_MUL].prod[j] = '0;
      end

      // clamp below the last point
      pw = CMP_W'(st[S_CLP-1].prod[j] >> F);
      nx[S_CLP].pos[j] = (pw > CMP_W'(lim[j])) ? lim[j] : POS_W'(pw);
    end

    // neighbor addresses
    rl = st[S_ADR-1].pos[0][POS_W-1:F];
    cm = st[S_ADR-1].pos[1][POS_W-1:F];
    nx[S_ADR].addr[0] = ADDR_W'(int'(rl) * MU_POINTS + int'(cm));
    nx[S_ADR].addr[1] = ADDR_W'(int'(rl) * MU_POINTS + int'(cm) + 1);
    nx[S_ADR].addr[2] = ADDR_W'((int'(rl) + 1) * MU_POINTS + int'(cm));
    nx[S_ADR].addr[3] = ADDR_W'((int'(rl) + 1) * MU_POINTS + int'(cm) + 1);
    nx[S_ADR].fl      = st[S_ADR-1].pos[0][F-1:0];
    nx[S_ADR].fm      = st[S_ADR-1].pos[1][F-1:0];

    // blend along mu: weighted products
    for (int k = 0; k < 4; k++) begin
      wf = k[0] ? {1'b0, st[S_CEL].fm} : ONE_W - {1'b0, st[S_CEL].fm};
      ca = PR_W'($signed(cellv[k]));
      wb = PR_W'(wf);
      nx[S_BL1].pr[k] = ca * wb;
    end

    // round to nearest
    s = SUM_W'($signed(st[S_BL1].pr[0])) + SUM_W'($signed(st[S_BL1].pr[1])) + HALF;
    t = s >>> F;
    nx[S_BL2].top = t[31:0];
    s = SUM_W'($signed(st[S_BL1].pr[2])) + SUM_W'($signed(st[S_BL1].pr[3])) + HALF;
    t = s >>> F;
    nx[S_BL2].bot = t[31:0];

    // blend along lambda
    ca = PR_W'($signed(st[S_BL2].top));
    wb = PR_W'(ONE_W - {1'b0, st[S_BL2].fl});
    nx[S_BL3].pr[0] = ca * wb;
    ca = PR_W'($signed(st[S_BL2].bot));
    wb = PR_W'({1'b0, st[S_BL2].fl});
    nx[S_BL3].pr[1] = ca * wb;

    // round and saturate
    s = SUM_W'($signed(st[S_BL3].pr[0])) + SUM_W'($signed(st[S_BL3].pr[1])) + HALF;
    t = s >>> F;
    if (t > RES_MAX) begin
      nx[LAST].res = 32'h7fffffff;
    end else if (t < RES_MIN) begin
      nx[LAST].res = 32'h80000000;
    end else begin
      nx[LAST].res = t[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], request.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NST; k++) begin
        st[k] <= nx[k];
      end
    end
  end

  // four copies of the grid, one per neighbor; writes land at the read stage
  logic tbl_we;
  assign tbl_we = en && vld[S_ADR] && st[S_ADR].wok;

  for (genvar g = 0; g < 4; g++) begin : g_bank
    lgbt_ram #(
      .WIDTH(32),
      .DEPTH(DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (tbl_we),
      .waddr (st[S_ADR].waddr),
      .wdata (st[S_ADR].entry),
      .re    (en),
      .raddr (st[S_ADR].addr[g]),
      .rdata (cellv[g])
    );
  end

  assign result.valid        = vld[LAST] && st[LAST].kind == KIND_QUERY;
  assign result.interpolated = st[LAST].res;

  // pipe holds only behind a full, untaken output
  a_hold_only_on_backpressure: assert property (@(posedge clk) disable iff (rst)
    !request.ready |-> result.valid && !result.ready)
    else $error("pipe held without backpressure");

  a_pos_clamped: assert property (@(posedge clk) disable iff (rst)
    vld[S_CLP] && st[S_CLP].kind == KIND_QUERY
    |-> st[S_CLP].pos[0] <= lim[0] && st[S_CLP].pos[1] <= lim[1])
    else $error("grid position beyond last point");

  a_addr_in_table: assert property (@(posedge clk) disable iff (rst)
    vld[S_ADR] && st[S_ADR].kind == KIND_QUERY |-> int'(st[S_ADR].addr[3]) < DEPTH)
    else $error("neighbor address outside table");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    en && vld[LAST-1] && st[LAST-1].kind == KIND_WRITE |=> !result.valid)
    else $error("write produced a result");

endmodule

[dv/lgbt_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgbt_checker
// Watches the request, result and configuration ports of the log-grid
// lookup. It keeps its own copy of the registers and the grid, predicts each
// query answer, and compares the answers in order.
// ----------------------------------------------------------------------------
module lgbt_checker (
  input  logic                 clk,
  input  logic                 rst,
  lgbt_request_if              req,
  lgbt_result_if               res,
  input  logic                 cfg_enable,
  input  lgbt_pkg::reg_index_t cfg_index,
  input  lgbt_pkg::cfg_data_t  cfg_data,
  output int                   mismatches,
  output int                   pending
);

  import lgbt_pkg::*;

  localparam int FRAC   = 16;
  localparam int POINTS = 64;

  logic [23:0] min_lambda, step_lambda, min_mu, step_mu;
  logic [6:0]  cnt_lambda, cnt_mu;
  logic [31:0] grid [0:POINTS*POINTS-1];
  logic [31:0] answers_q [$];

  // truncated log2 in signed Q8.16
  function automatic longint log2_q(logic [31:0] x);
    int          msb;
    logic [63:0] m;
    longint      frac;
    if (x == 0) return LOG_FLOOR;
    msb = 31;
    while (!x[msb]) msb--;
    m = 64'(x) << (31 - msb);
    frac = 0;
    for (int i = 0; i < FRAC; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return longint'(msb - VALUE_FRAC) * (longint'(1) << FRAC) + frac;
  endfunction

  function automatic logic [63:0] position(logic [31:0] x, logic [23:0] lmin,
                                           logic [23:0] inv, logic [6:0] cnt);
    longint      d;
    int          c;
    logic [63:0] lim, p;
    d = log2_q(x) - longint'($signed(lmin));
    c = cnt;
    if (c < 2) c = 2;
    if (c > POINTS) c = POINTS;
    lim = (64'(c - 1) << FRAC) - 1;
    if (d <= 0) return 0;
    p = (64'(d) * 64'(inv)) >> FRAC;
    return (p > lim) ? lim : p;
  endfunction

  // a*(1-f) + b*f, rounded to nearest, ties up
  function automatic longint mix(longint a, longint b, logic [63:0] f);
    longint      s;
    logic [63:0] t;
    s = a * ((longint'(1) << FRAC) - longint'(f)) + b * longint'(f);
    t = (64'(s) + (64'd1 << (31 + FRAC)) + (64'd1 << (FRAC - 1))) >> FRAC;
    return longint'(t) - (longint'(1) << 31);
  endfunction

  function automatic longint word(int r, int c);
    return longint'($signed(grid[r*POINTS + c]));
  endfunction

  function automatic logic [31:0] interpolate(logic [31:0] lam, logic [31:0] mu);
    logic [63:0] pl, pm, fl, fm;
    int          r, c;
    longint      top, bot, v;
    pl = position(lam, min_lambda, step_lambda, cnt_lambda);
    pm = position(mu, min_mu, step_mu, cnt_mu);
    r  = int'(pl >> FRAC);
    c  = int'(pm >> FRAC);
    fl = pl & ((64'd1 << FRAC) - 1);
    fm = pm & ((64'd1 << FRAC) - 1);
    top = mix(word(r, c), word(r, c + 1), fm);
    bot = mix(word(r + 1, c), word(r + 1, c + 1), fm);
    v = mix(top, bot, fl);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  always @(posedge clk) begin
    logic [31:0] want;
    if (rst) begin
      min_lambda  = '0;
      step_lambda = 24'd65536;
      cnt_lambda  = 7'd64;
      min_mu      = '0;
      step_mu     = 24'd65536;
      cnt_mu      = 7'd64;
      answers_q.delete();
      mismatches  = 0;
    end else begin
      if (cfg_enable) begin
        case (cfg_index)
          REG_LOG_MIN_LAMBDA:  min_lambda  = cfg_data;
          REG_INV_STEP_LAMBDA: step_lambda = cfg_data;
          REG_COUNT_LAMBDA:    cnt_lambda  = cfg_data[6:0];
          REG_LOG_MIN_MU:      min_mu      = cfg_data;
          REG_INV_STEP_MU:     step_mu     = cfg_data;
          REG_COUNT_MU:        cnt_mu      = cfg_data[6:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        if (req.kind == KIND_WRITE) grid[req.row*POINTS + req.column] = req.entry;
        else answers_q.push_back(interpolate(req.lambda_value, req.mu_value));
      end
      if (res.valid && res.ready) begin
        if (answers_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result transaction %h", $realtime, res.interpolated);
        end else begin
          want = answers_q.pop_front();
          if (res.interpolated !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: interpolated expected %h actual %h", $realtime, want,
                       res.interpolated);
          end
        end
      end
    end
    pending = answers_q.size();
  end

endmodule

[dv/tb_log_grid_bilinear_table_lookup_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_log_grid_bilinear_table_lookup_top
// Fills the used corner of the grid, runs directed queries at the argument
// and register extremes, then random query/write traffic over several
// register settings with random stalls on both channels in all but the last
// setting. The checker gives the verdict count.
// ----------------------------------------------------------------------------
module tb_log_grid_bilinear_table_lookup_top;
  import lgbt_pkg::*;

  // rows and columns that queries may reach; random counts stay within this corner
  localparam int GRID_USED = 17;

  logic       clk = 0;
  logic       rst = 1;
  logic       cfg_enable = 0;
  reg_index_t cfg_index = REG_LOG_MIN_LAMBDA;
  cfg_data_t  cfg_data = '0;
  logic       stalls_on = 1;
  int         mismatches, pending, quiet, hold;

  lgbt_request_if request();
  lgbt_result_if  result();

  log_grid_bilinear_table_lookup_top DUT (
    .clk(clk), .rst(rst), .request(request), .result(result),
    .cfg_enable(cfg_enable), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  lgbt_checker u_checker (
    .clk(clk), .rst(rst), .req(request), .res(result),
    .cfg_enable(cfg_enable), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    request.valid = 0;
    request.kind = KIND_QUERY;
    request.lambda_value = 0;
    request.mu_value = 0;
    request.row = 0;
    request.column = 0;
    request.entry = 0;
    result.ready = 0;
  end

  // result side stalls in short bursts
  always @(negedge clk) begin
    if (hold > 0) begin
      hold--;
      result.ready <= 0;
    end else if (stalls_on && $urandom_range(0, 4) == 0) begin
      hold = $urandom_range(0, 2);
      result.ready <= 0;
    end else begin
      result.ready <= 1;
    end
  end

  always @(posedge clk) begin
    if (rst || (request.valid && request.ready) || (result.valid && result.ready)) quiet = 0;
    else quiet++;
    if (quiet >= 5000) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send(logic k, logic [31:0] lam, logic [31:0] mu, logic [5:0] r,
                      logic [5:0] c, logic [31:0] e);
    @(negedge clk);
    if (stalls_on && $urandom_range(0, 3) == 0) begin
      request.valid <= 0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    request.valid <= 1;
    request.kind <= k;
    request.lambda_value <= lam;
    request.mu_value <= mu;
    request.row <= r;
    request.column <= c;
    request.entry <= e;
    @(posedge clk);
    while (!request.ready) @(posedge clk);
  endtask

  task automatic query(logic [31:0] lam, logic [31:0] mu);
    send(KIND_QUERY, lam, mu, 6'($urandom), 6'($urandom), $urandom);
  endtask

  task automatic store(logic [5:0] r, logic [5:0] c, logic [31:0] e);
    send(KIND_WRITE, $urandom, $urandom, r, c, e);
  endtask

  // drain, let trailing writes clear the pipe, then leave the bus idle
  task automatic drain();
    @(negedge clk);
    request.valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic configure(logic [23:0] lml, logic [23:0] isl, logic [6:0] cl,
                           logic [23:0] lmm, logic [23:0] ism, logic [6:0] cm);
    reg_index_t idx [6] = '{REG_LOG_MIN_LAMBDA, REG_INV_STEP_LAMBDA, REG_COUNT_LAMBDA,
                            REG_LOG_MIN_MU, REG_INV_STEP_MU, REG_COUNT_MU};
    logic [23:0] val [6];
    val = '{lml, isl, 24'(cl), lmm, ism, 24'(cm)};
    drain();
    foreach (idx[i]) begin
      cfg_enable <= 1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(negedge clk);
    end
    cfg_enable <= 0;
  endtask

  function automatic logic [31:0] argument();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic logic [31:0] table_word();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return $urandom;
      default: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
    endcase
  endfunction

  task automatic random_traffic(int n);
    repeat (n) begin
      if ($urandom_range(0, 4) == 0) store(6'($urandom), 6'($urandom), table_word());
      else query(argument(), argument());
    end
  endtask

  initial begin
    int span;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // every reachable grid word written before any query can read it
    stalls_on = 0;
    for (int r = 0; r < GRID_USED; r++)
      for (int c = 0; c < GRID_USED; c++) store(6'(r), 6'(c), table_word());
    stalls_on = 1;

    // directed: argument extremes under reset registers
    query(0, 0);
    query(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    query(1, 32'h0001_0000);
    query(32'h0001_0000, 1);
    query(32'h0001_8000, 32'h0002_C000);
    store(6'd16, 6'd16, 32'h7FFF_FFFF);
    store(6'd15, 6'd15, 32'h8000_0000);
    store(6'd15, 6'd16, 32'h7FFF_FFFF);
    store(6'd16, 6'd15, 32'h8000_0000);
    query(32'hFFFF_FFFF, 32'h8000_0000);
    query(32'h7FFF_FFFF, 32'hFFFF_FFFF);

    // minimum counts, huge step, log_min at its top for lambda and its bottom for mu: positions pinned
    configure(24'h7FFFFF, 24'hFFFFFF, 7'd0, 24'h800000, 24'hFFFFFF, 7'd1);
    query(0, 0);
    query(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    query(32'h0000_0100, 32'h0100_0000);
    // count above the grid, smallest step, lowest log_min for lambda and highest for mu
    configure(24'h800000, 24'd1, 7'd127, 24'h7FFFFF, 24'd1, 7'd65);
    query(0, 32'hFFFF_FFFF);
    query(32'hFFFF_FFFF, 0);
    query(32'h0003_0000, 32'h0000_0003);
    // zero step through a full-width write
    configure(24'hF00000, 24'd0, 7'd64, 24'hF00000, 24'd0, 7'd64);
    query(32'h1234_5678, 32'h0000_0001);
    query(32'hFFFF_FFFF, 32'h0000_FFFF);

    // random settings; log grid spanning roughly the argument range
    for (int ph = 0; ph < 8; ph++) begin
      logic [6:0] cl, cm;
      cl = (ph == 1) ? 7'd2 : (ph == 2) ? 7'(GRID_USED) : 7'($urandom_range(2, GRID_USED));
      cm = (ph == 1) ? 7'(GRID_USED) : (ph == 2) ? 7'd2 : 7'($urandom_range(2, GRID_USED));
      span = $urandom_range(4, 32);
      configure(24'(-$urandom_range(0, 16 << 16)), 24'((int'(cl) - 1) * 65536 / span),
                cl, 24'(-$urandom_range(0, 16 << 16)),
                24'($urandom_range(1, 2) * (int'(cm) - 1) * 65536 / span), cm);
      if (ph == 7) stalls_on = 0;
      random_traffic(65);
      if (ph == 3) begin
        // sender holds off until the pipe has answered everything
        @(negedge clk);
        request.valid <= 0;
        while (pending != 0) @(negedge clk);
        random_traffic(20);
      end
    end

    @(negedge clk);
    request.valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
